FILE: rtl/core/stepdown_level_planner_top_defines.svh
// Assertion macros shared by the planner checker.
`ifndef STEPDOWN_LEVEL_PLANNER_TOP_DEFINES_SVH
`define STEPDOWN_LEVEL_PLANNER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SDLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SDLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sdlp_pkg.sv
// Shared types and constants of the stepdown level planner.
package sdlp_pkg;

  localparam int unsigned MAX_LEVELS_DEF  = 63;
  localparam int unsigned HEIGHT_BITS_DEF = 32;
  localparam int unsigned STEP_BITS       = 31;
  localparam int unsigned CFG_IDX_BITS    = 2;
  localparam int unsigned CFG_DATA_DEF    = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] REG_STOCK_TOP  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FACE       = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_DEPTH = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FILL,
    ST_EXTRA,
    ST_INSERT,
    ST_EMIT
  } plan_state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLR,
    CELL_CMP,
    CELL_INS,
    CELL_APPEND,
    CELL_SHL
  } cell_op_e;

  typedef struct packed {
    logic valid;
    logic keep;
    logic near;
  } cell_stat_t;

endpackage

FILE: rtl/core/sdlp_intf.sv
// Channel interfaces of the stepdown level planner.
interface sdlp_item_if #(
  parameter int unsigned HEIGHT_BITS = sdlp_pkg::HEIGHT_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] extra_level;
  logic                          has_level;
  logic                          last;

  modport source (output valid, extra_level, has_level, last, input ready);
  modport sink   (input valid, extra_level, has_level, last, output ready);
endinterface

interface sdlp_result_if #(
  parameter int unsigned HEIGHT_BITS = sdlp_pkg::HEIGHT_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] cut_depth_z;
  logic                          final_cut;
  logic                          plan_valid;
  logic                          pass_limit_hit;

  modport source (output valid, cut_depth_z, final_cut, plan_valid, pass_limit_hit,
                  input ready);
  modport sink   (input valid, cut_depth_z, final_cut, plan_valid, pass_limit_hit,
                  output ready);
endinterface

interface sdlp_cfg_if #(
  parameter int unsigned DATA_BITS = sdlp_pkg::CFG_DATA_DEF
);
  logic                              valid;
  logic                              ready;
  logic [sdlp_pkg::CFG_IDX_BITS-1:0] reg_idx;
  logic [DATA_BITS-1:0]              wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

FILE: rtl/core/sdlp_cell.sv
// One cell of the sorted level chain: holds a level and trades it with its neighbors.
module sdlp_cell #(
  parameter int unsigned HEIGHT_BITS = sdlp_pkg::HEIGHT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sdlp_pkg::cell_op_e            op_i,
  input  logic signed [HEIGHT_BITS-1:0] x_i,
  input  logic                          prev_keep_i,
  input  logic                          prev_valid_i,
  input  logic signed [HEIGHT_BITS-1:0] prev_value_i,
  input  logic                          next_valid_i,
  input  logic signed [HEIGHT_BITS-1:0] next_value_i,
  output logic signed [HEIGHT_BITS-1:0] value_o,
  output sdlp_pkg::cell_stat_t          stat_o
);

  logic signed [HEIGHT_BITS-1:0] value_q, value_d;
  logic                          valid_q, valid_d;
  logic                          gt_q, gt_d;
  logic                          near_q, near_d;
  logic signed [HEIGHT_BITS:0]   diff;
  logic                          keep;

  assign diff = {value_q[HEIGHT_BITS-1], value_q} - {x_i[HEIGHT_BITS-1], x_i};
  // Hold the entry when it stays ahead of the new level, or whenever it is valid during an append.
  assign keep = valid_q & ((op_i == sdlp_pkg::CELL_APPEND) | gt_q);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    gt_d    = gt_q;
    near_d  = near_q;
    unique case (op_i)
      sdlp_pkg::CELL_HOLD: begin
      end
      sdlp_pkg::CELL_CLR: begin
        valid_d = 1'b0;
      end
      sdlp_pkg::CELL_CMP: begin
        gt_d   = valid_q & (value_q > x_i);
        near_d = valid_q & ((diff == '0) || (diff == (HEIGHT_BITS+1)'(1)) || (diff == '1));
      end
      sdlp_pkg::CELL_INS, sdlp_pkg::CELL_APPEND: begin
        if (keep) begin
          value_d = value_q;
        end else if (prev_keep_i) begin
          value_d = x_i;
          valid_d = 1'b1;
        end else begin
          value_d = prev_value_i;
          valid_d = prev_valid_i;
        end
      end
      sdlp_pkg::CELL_SHL: begin
        value_d = next_value_i;
        valid_d = next_valid_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    gt_q    <= gt_d;
    near_q  <= near_d;
  end

  assign value_o      = value_q;
  assign stat_o.valid = valid_q;
  assign stat_o.keep  = keep;
  assign stat_o.near  = near_q;

endmodule

FILE: rtl/core/stepdown_level_planner_top.sv
// Top level of the stepdown level planner: config registers, sequencer, cell chain.
//
// Channels: cfg_i writes stock top (index 0), face height (index 1) and step
// depth (index 2); ready is always high. item_i takes one word per item
// (extra_level, has_level, last); result_o returns the planned pass heights.
// The first item of a plan clears the chain and fills it with stock top minus
// k steps while above the face, one level per cycle. An extra level is
// compared against every cell in parallel and inserted in the next cycle, the cells
// below it shifting down one place. An item with last set drains the chain
// head first, one word per cycle while the receiver takes them, then sends
// the face height with final_cut. An item runs through the states clear and
// fill (first item of a plan; fill only on a valid plan), extra, insert (with
// an extra level) and emit (last item), where the drain shifts the chain.
// Reset clears the config registers, the chain valid bits and all control
// state; level values carry no reset. When the receiver stalls the pending
// result word holds in the output register and the drain stops; the item
// side stays blocked until the item in work has finished.
module stepdown_level_planner_top #(
  parameter int unsigned MAX_LEVELS  = sdlp_pkg::MAX_LEVELS_DEF,
  parameter int unsigned HEIGHT_BITS = sdlp_pkg::HEIGHT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sdlp_cfg_if.sink             cfg_i,
  sdlp_item_if.sink            item_i,
  sdlp_result_if.source        result_o
);

  localparam int unsigned STEP_W = sdlp_pkg::STEP_BITS;
  // Wide enough for top minus step and one more step below the face.
  localparam int unsigned ZW     = ((HEIGHT_BITS > STEP_W) ? HEIGHT_BITS : STEP_W) + 2;
  localparam int unsigned CNT_W  = $clog2(MAX_LEVELS + 1);

  localparam logic [CNT_W-1:0] CntMax  = CNT_W'(MAX_LEVELS);
  localparam logic [CNT_W:0]   CntMaxW = (CNT_W+1)'(MAX_LEVELS);

  // Configuration registers.
  logic signed [HEIGHT_BITS-1:0] top_q;
  logic signed [HEIGHT_BITS-1:0] face_q;
  logic [STEP_W-1:0]             step_q;

  // Plan state.
  sdlp_pkg::plan_state_e state_q, state_d;
  logic [CNT_W-1:0]      count_q;
  logic                  limit_q;
  logic                  started_q;
  logic signed [ZW-1:0]  z_q;

  // Latched item.
  logic signed [HEIGHT_BITS-1:0] item_x_q;
  logic                          item_has_q;
  logic                          item_last_q;

  // Output register.
  logic                          res_valid_q;
  logic signed [HEIGHT_BITS-1:0] res_z_q;
  logic                          res_final_q;
  logic                          res_pv_q;
  logic                          res_lim_q;

  // Chain wiring.
  logic signed [HEIGHT_BITS-1:0] cell_val [MAX_LEVELS];
  sdlp_pkg::cell_stat_t          cell_st  [MAX_LEVELS];
  logic [MAX_LEVELS-1:0]         near_vec;
  sdlp_pkg::cell_op_e            cell_op;
  logic signed [HEIGHT_BITS-1:0] cell_x;

  // Sequencer controls.
  logic use_z, cnt_inc, plan_clr, lim_set, start_set, z_load, z_dec;
  logic out_load, face_word;

  logic                 item_acc;
  logic                 plan_ok;
  logic signed [ZW-1:0] top_ext, face_ext, step_ext;
  logic                 z_above;
  logic                 fill_last;
  logic                 store_full;
  logic                 x_in_range;
  logic                 extra_go;
  logic                 near_any;
  logic                 head_emit;
  logic                 out_free;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      face_q <= '0;
      step_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_idx)
        sdlp_pkg::REG_STOCK_TOP:  top_q  <= cfg_i.wdata[HEIGHT_BITS-1:0];
        sdlp_pkg::REG_FACE:       face_q <= cfg_i.wdata[HEIGHT_BITS-1:0];
        sdlp_pkg::REG_STEP_DEPTH: step_q <= cfg_i.wdata[STEP_W-1:0];
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Decisions
  // ---------------------------------------------------------------------------
  assign item_i.ready = (state_q == sdlp_pkg::ST_IDLE);
  assign item_acc     = item_i.valid && item_i.ready;

  assign plan_ok  = (step_q != '0) && (top_q > face_q);
  assign top_ext  = {{(ZW-HEIGHT_BITS){top_q[HEIGHT_BITS-1]}}, top_q};
  assign face_ext = {{(ZW-HEIGHT_BITS){face_q[HEIGHT_BITS-1]}}, face_q};
  assign step_ext = {{(ZW-STEP_W){1'b0}}, step_q};

  assign z_above    = z_q > face_ext;
  assign fill_last  = z_above && (({1'b0, count_q} + (CNT_W+1)'(1)) >= CntMaxW);
  assign store_full = (count_q >= CntMax);
  assign x_in_range = (item_x_q > face_q) && (item_x_q < top_q);
  assign extra_go   = item_has_q && plan_ok && x_in_range;
  assign near_any   = |near_vec;
  assign head_emit  = plan_ok && cell_st[0].valid;
  assign out_free   = !res_valid_q || result_o.ready;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdlp_pkg::ST_IDLE: begin
        if (item_acc) begin
          state_d = started_q ? sdlp_pkg::ST_EXTRA : sdlp_pkg::ST_CLEAR;
        end
      end
      sdlp_pkg::ST_CLEAR: begin
        state_d = plan_ok ? sdlp_pkg::ST_FILL : sdlp_pkg::ST_EXTRA;
      end
      sdlp_pkg::ST_FILL: begin
        if (!z_above || fill_last) begin
          state_d = sdlp_pkg::ST_EXTRA;
        end
      end
      sdlp_pkg::ST_EXTRA: begin
        if (extra_go) begin
          state_d = sdlp_pkg::ST_INSERT;
        end else begin
          state_d = item_last_q ? sdlp_pkg::ST_EMIT : sdlp_pkg::ST_IDLE;
        end
      end
      sdlp_pkg::ST_INSERT: begin
        state_d = item_last_q ? sdlp_pkg::ST_EMIT : sdlp_pkg::ST_IDLE;
      end
      sdlp_pkg::ST_EMIT: begin
        if (out_free && !head_emit) begin
          state_d = sdlp_pkg::ST_IDLE;
        end
      end
      default: state_d = sdlp_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: controls
  // ---------------------------------------------------------------------------
  always_comb begin
    cell_op   = sdlp_pkg::CELL_HOLD;
    use_z     = 1'b0;
    cnt_inc   = 1'b0;
    plan_clr  = 1'b0;
    lim_set   = 1'b0;
    start_set = 1'b0;
    z_load    = 1'b0;
    z_dec     = 1'b0;
    out_load  = 1'b0;
    face_word = 1'b0;
    unique case (state_q)
      sdlp_pkg::ST_IDLE: begin
      end
      sdlp_pkg::ST_CLEAR: begin
        // start a new plan: empty chain, first candidate level
        cell_op   = sdlp_pkg::CELL_CLR;
        plan_clr  = 1'b1;
        start_set = 1'b1;
        z_load    = 1'b1;
      end
      sdlp_pkg::ST_FILL: begin
        if (z_above) begin
          cell_op = sdlp_pkg::CELL_APPEND;
          use_z   = 1'b1;
          cnt_inc = 1'b1;
          z_dec   = 1'b1;
          lim_set = fill_last;
        end
      end
      sdlp_pkg::ST_EXTRA: begin
        if (extra_go) begin
          cell_op = sdlp_pkg::CELL_CMP;
        end
      end
      sdlp_pkg::ST_INSERT: begin
        // drop levels within one unit of a stored one; flag a full store
        if (near_any) begin
          cell_op = sdlp_pkg::CELL_HOLD;
        end else if (store_full) begin
          lim_set = 1'b1;
        end else begin
          cell_op = sdlp_pkg::CELL_INS;
          cnt_inc = 1'b1;
        end
      end
      sdlp_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (head_emit) begin
            cell_op = sdlp_pkg::CELL_SHL;
          end else begin
            // face word closes the plan
            face_word = 1'b1;
            cell_op   = sdlp_pkg::CELL_CLR;
            plan_clr  = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdlp_pkg::ST_IDLE;
      count_q     <= '0;
      limit_q     <= 1'b0;
      started_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (plan_clr) begin
        count_q <= '0;
        limit_q <= 1'b0;
      end else begin
        if (cnt_inc) begin
          count_q <= count_q + CNT_W'(1);
        end
        if (lim_set) begin
          limit_q <= 1'b1;
        end
      end
      if (start_set) begin
        started_q <= 1'b1;
      end else if (face_word) begin
        started_q <= 1'b0;
      end
      if (out_load) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (item_acc) begin
      item_x_q    <= item_i.extra_level;
      item_has_q  <= item_i.has_level;
      item_last_q <= item_i.last;
    end
    if (z_load) begin
      z_q <= top_ext - step_ext;
    end else if (z_dec) begin
      z_q <= z_q - step_ext;
    end
    if (out_load) begin
      res_z_q     <= face_word ? face_q : cell_val[0];
      res_final_q <= face_word;
      res_pv_q    <= face_word ? plan_ok : 1'b1;
      res_lim_q   <= plan_ok && limit_q;
    end
  end

  assign result_o.valid          = res_valid_q;
  assign result_o.cut_depth_z    = res_z_q;
  assign result_o.final_cut      = res_final_q;
  assign result_o.plan_valid     = res_pv_q;
  assign result_o.pass_limit_hit = res_lim_q;

  // ---------------------------------------------------------------------------
  // Level chain, head at cell 0, descending toward the tail
  // ---------------------------------------------------------------------------
  assign cell_x = use_z ? z_q[HEIGHT_BITS-1:0] : item_x_q;

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    logic                          prev_keep;
    logic                          prev_valid;
    logic signed [HEIGHT_BITS-1:0] prev_value;
    logic                          next_valid;
    logic signed [HEIGHT_BITS-1:0] next_value;

    if (i == 0) begin : g_head
      assign prev_keep  = 1'b1;
      assign prev_valid = 1'b0;
      assign prev_value = '0;
    end else begin : g_body
      assign prev_keep  = cell_st[i-1].keep;
      assign prev_valid = cell_st[i-1].valid;
      assign prev_value = cell_val[i-1];
    end

    if (i == MAX_LEVELS - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_value = '0;
    end else begin : g_link
      assign next_valid = cell_st[i+1].valid;
      assign next_value = cell_val[i+1];
    end

    sdlp_cell #(
      .HEIGHT_BITS (HEIGHT_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .op_i         (cell_op),
      .x_i          (cell_x),
      .prev_keep_i  (prev_keep),
      .prev_valid_i (prev_valid),
      .prev_value_i (prev_value),
      .next_valid_i (next_valid),
      .next_value_i (next_value),
      .value_o      (cell_val[i]),
      .stat_o       (cell_st[i])
    );

    assign near_vec[i] = cell_st[i].near;
  end

endmodule

FILE: rtl/core/sdlp_checker.sv
// Port-level checks of the stepdown level planner, bound to the top level.
`include "stepdown_level_planner_top_defines.svh"

module sdlp_checker #(
  parameter int unsigned HEIGHT_BITS = sdlp_pkg::HEIGHT_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   item_valid_i,
  input logic                   item_ready_i,
  input logic                   res_valid_i,
  input logic                   res_ready_i,
  input logic [HEIGHT_BITS-1:0] res_z_i,
  input logic                   res_final_i,
  input logic                   res_pv_i,
  input logic                   res_lim_i
);

  // A stalled result word holds.
  `SDLP_ASSERT_NXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(res_z_i) && $stable(res_final_i) && $stable(res_pv_i) && $stable(res_lim_i), "stalled result word changed")

  // An accepted item blocks the input until it is worked off.
  `SDLP_ASSERT_NXT(a_item_busy, clk_i, rst_ni, item_valid_i && item_ready_i, !item_ready_i, "input ready right after an accepted word")

  // The limit flag only appears on a valid plan.
  `SDLP_ASSERT_IMP(a_lim_valid, clk_i, rst_ni, res_valid_i && res_lim_i, res_pv_i, "limit flag on an invalid plan")

  // An invalid plan sends the face word alone.
  `SDLP_ASSERT_IMP(a_invalid_face, clk_i, rst_ni, res_valid_i && !res_pv_i, res_final_i, "invalid plan word that is not the face")

endmodule

bind stepdown_level_planner_top sdlp_checker #(
  .HEIGHT_BITS (HEIGHT_BITS)
) u_sdlp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .item_valid_i (item_i.valid),
  .item_ready_i (item_i.ready),
  .res_valid_i  (result_o.valid),
  .res_ready_i  (result_o.ready),
  .res_z_i      (result_o.cut_depth_z),
  .res_final_i  (result_o.final_cut),
  .res_pv_i     (result_o.plan_valid),
  .res_lim_i    (result_o.pass_limit_hit)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the stepdown level planner: directed table, random plans.
module tb_top;

  localparam int unsigned PLAN_DEPTH = sdlp_pkg::MAX_LEVELS_DEF;
  localparam int unsigned IDX_W      = sdlp_pkg::CFG_IDX_BITS;
  localparam int unsigned DATA_W     = sdlp_pkg::CFG_DATA_DEF;
  localparam int unsigned STEP_W     = sdlp_pkg::STEP_BITS;
  localparam int unsigned HGT_W      = sdlp_pkg::HEIGHT_BITS_DEF;
  // Index 3 is not decoded by the block; a write there must change nothing.
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CLK_HALF      = 4;
  // Longest item: clear and fill plus an extra insert, with margin.
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 412;
  localparam int QUIET_AFTER   = 370;

  // One word on the result channel.
  typedef struct packed {
    logic signed [HGT_W-1:0] cut_depth_z;
    logic                    final_cut;
    logic                    plan_valid;
    logic                    pass_limit_hit;
  } pass_word_t;

  typedef enum logic {ROW_REG, ROW_ITEM} row_kind_e;

  // One row of the directed table: a register write or an item.
  typedef struct {
    row_kind_e           kind;
    logic [IDX_W-1:0]    idx;
    logic [DATA_W-1:0]   data;
    logic signed [31:0]  lvl;
    bit                  has;
    bit                  lst;
    bit                  typed;
    pass_word_t          want;
  } drill_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #(CLK_HALF) clk_i = ~clk_i;

  sdlp_cfg_if    cfg_bus ();
  sdlp_item_if   item_bus ();
  sdlp_result_if res_bus ();

  stepdown_level_planner_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .item_i   (item_bus),
    .result_o (res_bus)
  );

  // Shadow copy of the registers, as the block holds them.
  logic signed [31:0] top_cfg  = '0;
  logic signed [31:0] face_cfg = '0;
  logic [STEP_W-1:0]  step_cfg = '0;

  // Shadow copy of the plan under way.
  logic signed [31:0] level_q[$];
  bit                 limit_hit = 1'b0;
  bit                 plan_open = 1'b0;

  pass_word_t step_words[$];   // words caused by the item just accepted
  pass_word_t pending_q[$];    // words still owed by the block, oldest first

  drill_row_t drill[$];        // directed table

  int  fail_count   = 0;
  bit  quiet        = 1'b0;    // no idling on either side once set
  bit  hold_results = 1'b0;    // request for one long receiver hold-off
  bit  plan_traffic = 1'b0;    // items sent since the block was last seen idle
  int  sender_calm  = 0;

  // Settings of the current random plan, used to aim the extra levels.
  longint gen_top, gen_face, gen_step;
  bit     setup_ok;

  // ---------------------------------------------------------------------------
  // Level planning, mirrored

  function automatic void apply_reg(input logic [IDX_W-1:0] idx,
                                    input logic [DATA_W-1:0] data);
    case (idx)
      sdlp_pkg::REG_STOCK_TOP:  top_cfg  = data;
      sdlp_pkg::REG_FACE:       face_cfg = data;
      sdlp_pkg::REG_STEP_DEPTH: step_cfg = data[STEP_W-1:0];
      default: ;
    endcase
  endfunction

  // Stock top minus k steps while strictly above the face, up to the store limit.
  function automatic void fill_levels(input longint top, input longint face,
                                      input longint step);
    longint z;
    z = top - step;
    while (z > face) begin
      level_q.insert(level_q.size(), z[31:0]);
      if (level_q.size() >= PLAN_DEPTH) begin
        limit_hit = 1'b1;
        break;
      end
      z -= step;
    end
  endfunction

  // Insert an extra level in descending order; drop it when near a stored one.
  function automatic void insert_extra(input longint x, input longint top,
                                       input longint face);
    int     pos;
    longint d;
    if (x <= face || x >= top) return;
    foreach (level_q[i]) begin
      d = longint'(level_q[i]) - x;
      if (d >= -1 && d <= 1) return;
    end
    if (level_q.size() >= PLAN_DEPTH) begin
      limit_hit = 1'b1;
      return;
    end
    pos = 0;
    while (pos < level_q.size() && longint'(level_q[pos]) > x) pos++;
    level_q.insert(pos, x[31:0]);
  endfunction

  // Advance the plan by one item and collect the words it causes in step_words.
  function automatic void plan_item(input logic signed [31:0] lvl, input bit has,
                                    input bit lst);
    longint top, face, step;
    bit     ok, lim;
    top  = top_cfg;
    face = face_cfg;
    step = longint'(step_cfg);
    ok   = (step != 0) && (top > face);
    step_words.delete();
    // The first item of a plan clears the store and fills it from the current setup.
    if (!plan_open) begin
      level_q.delete();
      limit_hit = 1'b0;
      if (ok) fill_levels(top, face, step);
      plan_open = 1'b1;
    end
    if (has && ok) insert_extra(longint'(lvl), top, face);
    if (lst) begin
      lim = ok && limit_hit;
      if (ok) begin
        foreach (level_q[i]) begin
          step_words.insert(step_words.size(), pass_word_t'{level_q[i], 1'b0, 1'b1, lim});
        end
      end
      step_words.insert(step_words.size(), pass_word_t'{face_cfg, 1'b1, ok, lim});
      plan_open = 1'b0;
      level_q.delete();
      limit_hit = 1'b0;
    end
  endfunction

  function automatic void add_row(input drill_row_t row);
    drill.insert(drill.size(), row);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers

  // Drop both valids and wait until the block owes nothing and has gone quiet.
  task automatic settle_idle();
    item_bus.valid <= 1'b0;
    cfg_bus.valid  <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    // An item without results may still be at work; give it the longest item time.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    plan_traffic = 1'b0;
  endtask

  // Write one register; valid stays high so back-to-back writes need no gap.
  task automatic write_reg(input logic [IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] data);
    if (plan_traffic) settle_idle();
    cfg_bus.valid   <= 1'b1;
    cfg_bus.reg_idx <= idx;
    cfg_bus.wdata   <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    apply_reg(idx, data);
  endtask

  // Offer one item, wait for it to be taken, then book the words it owes.
  task automatic send_item(input logic signed [31:0] lvl, input bit has, input bit lst,
                           input bit typed = 1'b0, input pass_word_t want = '0);
    cfg_bus.valid <= 1'b0;
    if (sender_calm > 0) begin
      sender_calm--;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end else if ($urandom_range(0, 99) < 3) begin
      sender_calm = $urandom_range(20, 60);
    end
    item_bus.valid       <= 1'b1;
    item_bus.extra_level <= lvl;
    item_bus.has_level   <= has;
    item_bus.last        <= lst;
    do @(posedge clk_i); while (!item_bus.ready);
    plan_traffic = 1'b1;
    plan_item(lvl, has, lst);
    // A typed row replaces the mirrored words; the mirror still has to advance.
    if (typed) begin
      pending_q.insert(pending_q.size(), want);
    end else begin
      foreach (step_words[i]) pending_q.insert(pending_q.size(), step_words[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: compare each taken word with the oldest one owed

  always @(posedge clk_i) begin : check_words
    pass_word_t got;
    pass_word_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      got = pass_word_t'{res_bus.cut_depth_z, res_bus.final_cut, res_bus.plan_valid,
                         res_bus.pass_limit_hit};
      if (pending_q.size() == 0) begin
        $error("unexpected result word: cut_depth_z %0d final_cut %0b", got.cut_depth_z,
               got.final_cut);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (got.cut_depth_z !== want.cut_depth_z) begin
          $error("cut_depth_z: expected %0d, got %0d", want.cut_depth_z, got.cut_depth_z);
          fail_count++;
        end
        if (got.final_cut !== want.final_cut) begin
          $error("final_cut: expected %0b, got %0b", want.final_cut, got.final_cut);
          fail_count++;
        end
        if (got.plan_valid !== want.plan_valid) begin
          $error("plan_valid: expected %0b, got %0b", want.plan_valid, got.plan_valid);
          fail_count++;
        end
        if (got.pass_limit_hit !== want.pass_limit_hit) begin
          $error("pass_limit_hit: expected %0b, got %0b", want.pass_limit_hit,
                 got.pass_limit_hit);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver pacing: random stall bursts, calm stretches, one long hold-off

  initial begin : result_pacing
    int calm;
    calm = 0;
    res_bus.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        // Hold long enough for the drain to stop and the item side to back up.
        hold_results = 1'b0;
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        res_bus.ready <= 1'b1;
      end else if (calm > 0) begin
        calm--;
      end else if (!quiet && $urandom_range(0, 99) < 15) begin
        res_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        res_bus.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 4) begin
        calm = $urandom_range(20, 80);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random plan setup and extra levels

  // Pick a fresh setup: invalid plans, full-range values, extremes, or a
  // moderate span sized for anything from no levels to past the store limit.
  task automatic pick_setup();
    logic signed [31:0] t, f, a, b;
    logic [STEP_W-1:0] s;
    logic hi;
    longint span;
    int n;
    hi = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: begin
        t = $urandom;
        f = $urandom;
        s = '0;
      end
      1: begin
        a = $urandom;
        b = $urandom;
        if (a > b) begin
          t = b;
          f = a;
        end else begin
          t = a;
          f = b;
        end
        s = STEP_W'($urandom);
      end
      2: begin
        t = 32'h7FFF_FFFF - 32'($urandom_range(0, 1000));
        f = 32'h8000_0000 + 32'($urandom_range(0, 1000));
        s = STEP_W'($urandom_range(30_000_000, 32'h7FFF_FFFF));
      end
      3: begin
        t = $urandom;
        f = $urandom;
        s = STEP_W'($urandom);
      end
      default: begin
        f = $signed($urandom_range(0, 2_000_000)) - 1_000_000;
        s = STEP_W'(($urandom_range(0, 1) != 0) ? $urandom_range(1, 8)
                                                : $urandom_range(9, 30000));
        n = $urandom_range(0, 66);
        span = longint'(n) * longint'(s) + longint'($urandom_range(1, s));
        t = 32'(longint'(f) + span);
      end
    endcase
    write_reg(sdlp_pkg::REG_STOCK_TOP, t);
    write_reg(sdlp_pkg::REG_FACE, f);
    write_reg(sdlp_pkg::REG_STEP_DEPTH, {hi, s});
    gen_top  = t;
    gen_face = f;
    gen_step = longint'(s);
    setup_ok = (s != 0) && (t > f);
  endtask

  // Aim an extra level: inside the span, next to a fill level, on a bound, or noise.
  function automatic logic signed [31:0] pick_extra();
    longint span, x, r;
    int k;
    span  = gen_top - gen_face;
    k     = $urandom_range(0, 99);
    r     = $urandom;
    if (k < 45 && span > 1) begin
      x = gen_face + 1 + r % (span - 1);
    end else if (k < 70) begin
      x = gen_top - longint'($urandom_range(1, 66)) * gen_step
          + longint'($urandom_range(0, 4)) - 2;
    end else if (k < 80) begin
      case ($urandom_range(0, 3))
        0:       x = gen_face;
        1:       x = gen_top;
        2:       x = gen_face + 1;
        default: x = gen_top - 1;
      endcase
    end else begin
      x = $signed($urandom);
    end
    return x[31:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table rows

  function automatic drill_row_t reg_row(input logic [IDX_W-1:0] idx,
                                         input logic [DATA_W-1:0] data);
    drill_row_t row;
    row.kind  = ROW_REG;
    row.idx   = idx;
    row.data  = data;
    row.lvl   = '0;
    row.has   = 1'b0;
    row.lst   = 1'b0;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic drill_row_t item_row(input logic signed [31:0] lvl, input bit has,
                                          input bit lst);
    drill_row_t row;
    row.kind  = ROW_ITEM;
    row.idx   = '0;
    row.data  = '0;
    row.lvl   = lvl;
    row.has   = has;
    row.lst   = lst;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  // Closing item of an invalid plan: only the face comes back, flagged invalid.
  function automatic drill_row_t face_row(input logic signed [31:0] lvl, input bit has,
                                          input bit lst, input logic signed [31:0] face);
    drill_row_t row;
    row       = item_row(lvl, has, lst);
    row.typed = 1'b1;
    row.want  = pass_word_t'{face, 1'b1, 1'b0, 1'b0};
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus

  initial begin : stimulus
    logic signed [31:0] lvl, f;
    bit                 has, lst;
    int                 counted, plan_no, plan_len;

    rst_ni               <= 1'b0;
    item_bus.valid       <= 1'b0;
    item_bus.extra_level <= '0;
    item_bus.has_level   <= 1'b0;
    item_bus.last        <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.reg_idx      <= '0;
    cfg_bus.wdata        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset every register is zero, so the plan is invalid.
    add_row(face_row(32'sd0, 1'b0, 1'b1, 32'sd0));
    // Zero step depth: extras ignored, face only.
    add_row(reg_row(sdlp_pkg::REG_STOCK_TOP, 32'd1000));
    add_row(reg_row(sdlp_pkg::REG_FACE, 32'd0));
    add_row(reg_row(sdlp_pkg::REG_STEP_DEPTH, 32'd0));
    add_row(face_row(32'sd500, 1'b1, 1'b1, 32'sd0));
    // Fill 700/400/100; empty item opens the plan, then inserts, a near drop,
    // extras on the top and on the face, and a closing extra below the fill.
    add_row(reg_row(sdlp_pkg::REG_STEP_DEPTH, 32'd300));
    add_row(reg_row(REG_SPARE, 32'hA5A5_5A5A));
    add_row(item_row(32'h5A5A_A5A5, 1'b0, 1'b0));
    add_row(item_row(32'sd450, 1'b1, 1'b0));
    add_row(item_row(32'sd401, 1'b1, 1'b0));
    add_row(item_row(32'sd1000, 1'b1, 1'b0));
    add_row(item_row(32'sd0, 1'b1, 1'b0));
    add_row(item_row(32'sd1, 1'b1, 1'b1));
    // Face raised mid-plan: the fill stands, later extras see the new face.
    add_row(item_row(32'sd50, 1'b1, 1'b0));
    add_row(reg_row(sdlp_pkg::REG_FACE, 32'd200));
    add_row(item_row(32'sd150, 1'b1, 1'b1));
    // Top on the face, then top below the face.
    add_row(reg_row(sdlp_pkg::REG_STOCK_TOP, 32'd200));
    add_row(face_row(32'sd0, 1'b0, 1'b1, 32'sd200));
    add_row(reg_row(sdlp_pkg::REG_STOCK_TOP, -32'sd5));
    add_row(face_row(-32'sd100, 1'b1, 1'b1, 32'sd200));
    // Full height range with a unit step: fill stops at the limit, extra dropped.
    add_row(reg_row(sdlp_pkg::REG_STOCK_TOP, 32'h7FFF_FFFF));
    add_row(reg_row(sdlp_pkg::REG_FACE, 32'h8000_0000));
    add_row(reg_row(sdlp_pkg::REG_STEP_DEPTH, 32'd1));
    add_row(item_row(32'sd0, 1'b1, 1'b1));
    // Largest step with the spare top bit set; extras on both extremes.
    add_row(reg_row(sdlp_pkg::REG_STEP_DEPTH, 32'hFFFF_FFFF));
    add_row(item_row(32'h7FFF_FFFF, 1'b1, 1'b0));
    add_row(item_row(32'h8000_0000, 1'b1, 1'b1));
    // Fill one short of the limit, one insert fills it, the next is dropped.
    add_row(reg_row(sdlp_pkg::REG_STOCK_TOP, 32'd252));
    add_row(reg_row(sdlp_pkg::REG_FACE, 32'd0));
    add_row(reg_row(sdlp_pkg::REG_STEP_DEPTH, 32'd4));
    add_row(item_row(32'sd2, 1'b1, 1'b0));
    add_row(item_row(32'sd130, 1'b1, 1'b0));
    add_row(item_row(32'hFFFF_FFFF, 1'b0, 1'b1));

    foreach (drill[i]) begin
      if (drill[i].kind == ROW_REG) begin
        write_reg(drill[i].idx, drill[i].data);
      end else begin
        send_item(drill[i].lvl, drill[i].has, drill[i].lst, drill[i].typed, drill[i].want);
      end
    end

    // Random plans: mostly aimed extras, some noise, now and then a new setup.
    counted = 0;
    plan_no = 0;
    while (counted < RANDOM_ITEMS) begin
      if (plan_no == 0 || $urandom_range(0, 99) < 45) pick_setup();
      // Stall the receiver while this plan is offered so the block backs up.
      if (plan_no == 3) hold_results = 1'b1;
      plan_len = $urandom_range(1, 12);
      for (int j = 0; j < plan_len; j++) begin
        lst = (j == plan_len - 1);
        has = ($urandom_range(0, 99) < 85);
        lvl = pick_extra();
        send_item(lvl, has, lst);
        counted++;
        if (counted >= QUIET_AFTER) quiet = 1'b1;
        // Occasionally raise the face in the middle of a plan.
        if (!lst && setup_ok && $urandom_range(0, 99) < 3) begin
          f = 32'(gen_face + longint'($urandom_range(0, 4000)));
          write_reg(sdlp_pkg::REG_FACE, f);
          gen_face = f;
          setup_ok = (gen_step != 0) && (gen_top > gen_face);
        end
      end
      plan_no++;
    end

    // Drain: drop valid, wait for every owed word, then let the block go quiet.
    item_bus.valid <= 1'b0;
    cfg_bus.valid  <= 1'b0;
    quiet = 1'b1;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #(20_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
